// ===== hdl/vmu_pkg.sv =====
// vmu_pkg: shared types, constants and arithmetic helpers of the voxel math unit
// used by vmu_front, vmu_queue, vmu_back and voxel_math_unit; no dependencies
package vmu_pkg;

	// data format, signed fixed point
	localparam int DW = 32;
	localparam int FB = 16;
	// wide magnitude width for saturation
	localparam int MW = 2 * DW + 2;
	// quotient bits produced by the divide pipeline
	localparam int QB = DW + 1;
	// dividend width (percent difference needs |a-b| * 100 * 2^FB)
	localparam int NW = DW + FB + 8;
	// square root bits and working width
	localparam int RB = (DW + FB) / 2;
	localparam int SW = 2 * RB + 2;
	// front to back queue
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	// configuration index width
	localparam int CIW = 3;

	typedef logic signed [DW-1:0] data_t;
	typedef logic [DW-1:0] umag_t;

	localparam data_t ONE = data_t'(64'd1 << FB);
	localparam data_t DMAX = {1'b0, {(DW-1){1'b1}}};
	localparam data_t DMIN = {1'b1, {(DW-1){1'b0}}};

	// operation codes
	typedef enum logic [4:0] {
		OP_ADD      = 5'd0,
		OP_SUB      = 5'd1,
		OP_MULT     = 5'd2,
		OP_DIV      = 5'd3,
		OP_SQRT     = 5'd4,
		OP_SQUARE   = 5'd5,
		OP_SCALE    = 5'd6,
		OP_CLAMP    = 5'd7,
		OP_SEGMENT  = 5'd8,
		OP_NSEGMENT = 5'd9,
		OP_PCTDIFF  = 5'd10,
		OP_EQ       = 5'd11,
		OP_NE       = 5'd12,
		OP_GT       = 5'd13,
		OP_GE       = 5'd14,
		OP_LT       = 5'd15,
		OP_LE       = 5'd16,
		OP_AND      = 5'd17,
		OP_OR       = 5'd18,
		OP_NOT      = 5'd19,
		OP_ISNAN    = 5'd20,
		OP_NISNAN   = 5'd21
	} op_t;

	// configuration register indexes
	localparam logic [CIW-1:0] CFG_OP_SELECT = 3'd0;
	localparam logic [CIW-1:0] CFG_SECOND_FROM_INPUT = 3'd1;
	localparam logic [CIW-1:0] CFG_CONST_A = 3'd2;
	localparam logic [CIW-1:0] CFG_CONST_B = 3'd3;
	localparam logic [CIW-1:0] CFG_ILLEGAL_GIVES_INVALID = 3'd4;

	// work class chosen by the front
	typedef enum logic [1:0] {
		CLS_LOGIC,
		CLS_MUL,
		CLS_DIV,
		CLS_SQRT
	} cls_t;

	typedef struct packed {
		data_t value_a;
		logic  valid_a;
		data_t value_b;
		logic  valid_b;
		logic  last_in;
	} in_item_t;

	typedef struct packed {
		data_t result_value;
		logic  result_valid;
		logic  last_out;
	} out_item_t;

	typedef struct packed {
		logic [4:0] op_select;
		logic       second_from_input;
		data_t      const_a;
		data_t      const_b;
		logic       illegal_gives_invalid;
	} cfg_t;

	// one classified item between front and back
	typedef struct packed {
		logic [4:0] op;
		cls_t       cls;
		logic       bad;
		data_t      a;
		data_t      b;
		umag_t      ma;
		umag_t      mb;
		logic       last;
	} q_entry_t;

	// magnitude of a signed value, the most negative value included
	function automatic umag_t mag_of(input data_t v);
		mag_of = v[DW-1] ? umag_t'(-v) : umag_t'(v);
	endfunction

	// saturate a sign and magnitude pair to the data range
	function automatic data_t sat_mag(input logic neg, input logic [MW-1:0] mag);
		logic [MW-1:0] lim_pos;
		logic [MW-1:0] lim_neg;
		lim_pos = MW'(DMAX);
		lim_neg = MW'(umag_t'(DMIN));
		if (!neg)
			sat_mag = (mag > lim_pos) ? DMAX : data_t'(mag[DW-1:0]);
		else if (mag > lim_neg)
			sat_mag = DMIN;
		else
			sat_mag = data_t'(-mag[DW-1:0]);
	endfunction

	// saturate a wide signed value to the data range
	function automatic data_t sat_signed(input logic signed [MW-1:0] v);
		if (!v[MW-1] && (|v[MW-2:DW-1]))
			sat_signed = DMAX;
		else if (v[MW-1] && !(&v[MW-2:DW-1]))
			sat_signed = DMIN;
		else
			sat_signed = data_t'(v[DW-1:0]);
	endfunction

	// integer magnitude rounded half to even
	function automatic logic [DW-FB:0] rint_mag(input data_t v);
		umag_t           m;
		logic [DW-FB:0]  q;
		logic [FB-1:0]   r;
		logic [FB-1:0]   half;
		m = mag_of(v);
		q = (DW-FB+1)'(m >> FB);
		r = m[FB-1:0];
		half = FB'(1) << (FB - 1);
		if (r > half || (r == half && q[0]))
			q = q + 1'b1;
		rint_mag = q;
	endfunction

endpackage

// ===== hdl/vmu_front.sv =====
// vmu_front: accepts voxel items, picks operand B, flags invalid operands and
// classifies the operation; depends on vmu_pkg
module vmu_front import vmu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  in_item_t item,
	input  cfg_t     cfg,
	input  logic     q_full,
	output logic     push,
	output q_entry_t entry
);

	logic     valid_s1;
	q_entry_t entry_s1;
	q_entry_t prep;
	logic     advance;
	logic     accept;

	// stage moves when empty or when the queue takes its item
	assign advance = !valid_s1 || !q_full;
	assign busy = !advance;
	assign accept = start && advance;
	assign push = valid_s1 && !q_full;
	assign entry = entry_s1;

	// operand selection and class decode
	always_comb begin
		prep.op = cfg.op_select;
		prep.a = item.value_a;
		prep.b = cfg.second_from_input ? item.value_b : cfg.const_a;
		prep.bad = !item.valid_a || (cfg.second_from_input && !item.valid_b);
		prep.ma = mag_of(prep.a);
		prep.mb = mag_of(prep.b);
		prep.last = item.last_in;
		case (op_t'(cfg.op_select))
			OP_MULT, OP_SQUARE, OP_SCALE: prep.cls = CLS_MUL;
			OP_DIV, OP_PCTDIFF:           prep.cls = CLS_DIV;
			OP_SQRT:                      prep.cls = CLS_SQRT;
			default:                      prep.cls = CLS_LOGIC;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= prep;
		end
	end

endmodule

// ===== hdl/vmu_queue.sv =====
// vmu_queue: short queue of classified items between front and back
// depends on vmu_pkg
module vmu_queue import vmu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_entry,
	input  logic     pop,
	output q_entry_t head,
	output logic     full,
	output logic     empty
);

	q_entry_t       slot_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = slot_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

endmodule

// ===== hdl/vmu_back.sv =====
// vmu_back: executes classified items: compare and logic ops, multiplier,
// pipelined divide and square root, final resolution; depends on vmu_pkg
module vmu_back import vmu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  q_entry_t  entry,
	input  cfg_t      cfg,
	output logic      pop,
	output out_item_t result,
	output logic      done
);

	typedef struct packed {
		logic [4:0] op;
		cls_t       cls;
		logic       bad;
		logic       neg;
		logic       illegal;
		logic       na;
		data_t      res;
		logic       res_ok;
		logic       last;
	} ctl_t;

	typedef struct packed {
		logic [DW:0]   rem;
		logic [QB-1:0] num;
		umag_t         den;
		logic [QB-1:0] quo;
		logic          sat;
	} div_t;

	typedef struct packed {
		logic [SW-1:0] rem;
		logic [RB-1:0] root;
	} sqr_t;

	// back always drains the queue
	assign pop = in_valid;

	// ---------------- stage 1: simple ops and multiplier ----------------
	ctl_t                ctl1;
	logic [DW:0]         mul_x;
	umag_t               mul_y;
	logic [2*DW:0]       prod;
	logic signed [MW-1:0] sum_w;
	logic signed [DW:0]  diff;
	logic [DW-FB:0]      ia;
	logic [DW-FB:0]      ib;
	logic                eq_i;
	logic                out_rng;

	logic          valid_s1;
	ctl_t          ctl_s1;
	logic [2*DW:0] prod_s1;
	umag_t         ma_s1;
	umag_t         mb_s1;

	always_comb begin
		diff = (DW+1)'(entry.a) - (DW+1)'(entry.b);
		ia = rint_mag(entry.a);
		ib = rint_mag(entry.b);
		eq_i = (ia == ib) && (ia == '0 || entry.a[DW-1] == entry.b[DW-1]);
		out_rng = (entry.a < cfg.const_a) || (entry.a > cfg.const_b);
		sum_w = '0;
		mul_x = (DW+1)'(entry.ma);
		mul_y = entry.mb;

		ctl1.op = entry.op;
		ctl1.cls = entry.cls;
		ctl1.bad = entry.bad;
		ctl1.na = entry.a[DW-1];
		ctl1.neg = entry.a[DW-1] ^ entry.b[DW-1];
		ctl1.illegal = 1'b0;
		ctl1.res = '0;
		ctl1.res_ok = 1'b1;
		ctl1.last = entry.last;

		case (op_t'(entry.op))
			OP_ADD: begin
				sum_w = MW'(entry.a) + MW'(entry.b);
				ctl1.res = sat_signed(sum_w);
			end
			OP_SUB: begin
				sum_w = MW'(entry.a) - MW'(entry.b);
				ctl1.res = sat_signed(sum_w);
			end
			OP_SQUARE: begin
				mul_y = entry.ma;
				ctl1.neg = 1'b0;
			end
			OP_SCALE: begin
				mul_y = mag_of(cfg.const_a);
				ctl1.neg = entry.a[DW-1] ^ cfg.const_a[DW-1];
			end
			OP_DIV: ctl1.illegal = (entry.mb == '0);
			OP_PCTDIFF: begin
				ctl1.illegal = (entry.a < cfg.const_a) || (entry.a == '0);
				mul_x = diff[DW] ? (DW+1)'(-diff) : (DW+1)'(diff);
				mul_y = umag_t'(100);
				ctl1.neg = diff[DW] ^ entry.a[DW-1];
			end
			OP_CLAMP: ctl1.res = (entry.a < cfg.const_a) ? cfg.const_a :
				((entry.a > cfg.const_b) ? cfg.const_b : entry.a);
			OP_SEGMENT:  ctl1.res = out_rng ? '0 : ONE;
			OP_NSEGMENT: ctl1.res = out_rng ? ONE : '0;
			OP_EQ:       ctl1.res = eq_i ? ONE : '0;
			OP_NE:       ctl1.res = eq_i ? '0 : ONE;
			OP_GT:       ctl1.res = (entry.a > entry.b) ? ONE : '0;
			OP_GE:       ctl1.res = (entry.a >= entry.b) ? ONE : '0;
			OP_LT:       ctl1.res = (entry.a < entry.b) ? ONE : '0;
			OP_LE:       ctl1.res = (entry.a <= entry.b) ? ONE : '0;
			OP_AND:      ctl1.res = (ia != '0 && ib != '0) ? ONE : '0;
			OP_OR:       ctl1.res = (ia != '0 || ib != '0) ? ONE : '0;
			OP_NOT:      ctl1.res = (ia == '0) ? ONE : '0;
			OP_ISNAN:    ctl1.res = '0;
			OP_NISNAN:   ctl1.res = ONE;
			OP_MULT, OP_SQRT: ctl1.res = '0;
			default:     ctl1.res_ok = 1'b0;
		endcase
		prod = (2*DW+1)'(mul_x) * (2*DW+1)'(mul_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			ctl_s1 <= ctl1;
			prod_s1 <= prod;
			ma_s1 <= entry.ma;
			mb_s1 <= entry.mb;
		end
	end

	// ---------------- stage 2: product rounding, divide and root setup ----------------
	ctl_t                 ctl2;
	logic [2*DW:0]        rnd_p;
	logic signed [MW-1:0] scaled;
	logic [NW-1:0]        dvd;
	umag_t                dvs;
	logic [NW-QB+DW-1:0]  dvd_hi;
	div_t                 div2;
	sqr_t                 sqr2;

	logic v_s [0:QB];
	ctl_t c_s [0:QB];
	div_t d_s [0:QB];
	sqr_t r_s [0:QB];

	always_comb begin
		ctl2 = ctl_s1;
		rnd_p = prod_s1 + (2*DW+1)'(64'd1 << (FB - 1));
		rnd_p = rnd_p >> FB;
		scaled = ctl_s1.neg ? -MW'(rnd_p) : MW'(rnd_p);
		scaled = scaled + MW'(cfg.const_b);
		if (ctl_s1.cls == CLS_MUL) begin
			if (op_t'(ctl_s1.op) == OP_SCALE)
				ctl2.res = sat_signed(scaled);
			else
				ctl2.res = sat_mag(ctl_s1.neg, MW'(rnd_p));
		end

		// dividend and divisor
		if (op_t'(ctl_s1.op) == OP_PCTDIFF) begin
			dvd = {prod_s1[DW+7:0], {FB{1'b0}}};
			dvs = ma_s1;
		end else begin
			dvd = NW'({ma_s1, {FB{1'b0}}});
			dvs = mb_s1;
		end
		dvd_hi = (NW-QB+DW)'(dvd[NW-1:QB]);
		div2.sat = (dvd_hi >= (NW-QB+DW)'(dvs));
		div2.rem = dvd_hi[DW:0];
		div2.num = dvd[QB-1:0];
		div2.den = dvs;
		div2.quo = '0;

		sqr2.rem = SW'({ma_s1, {FB{1'b0}}});
		sqr2.root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		c_s[0] <= ctl2;
		d_s[0] <= div2;
		r_s[0] <= sqr2;
	end

	// ---------------- one quotient bit per stage, one root bit in each of the first RB stages ----------------
	for (genvar k = 0; k < QB; k++) begin : g_step
		div_t        dn;
		sqr_t        rn;
		logic [DW:0] trial;

		always_comb begin
			dn = d_s[k];
			trial = {d_s[k].rem[DW-1:0], d_s[k].num[QB-1]};
			dn.num = {d_s[k].num[QB-2:0], 1'b0};
			if (trial >= (DW+1)'(d_s[k].den)) begin
				dn.rem = trial - (DW+1)'(d_s[k].den);
				dn.quo = {d_s[k].quo[QB-2:0], 1'b1};
			end else begin
				dn.rem = trial;
				dn.quo = {d_s[k].quo[QB-2:0], 1'b0};
			end
		end

		if (k < RB) begin : g_sq
			localparam int BIT = RB - 1 - k;
			logic [SW-1:0] delta;
			always_comb begin
				rn = r_s[k];
				delta = (SW'(r_s[k].root) << (BIT + 1)) + (SW'(1) << (2 * BIT));
				if (r_s[k].rem >= delta) begin
					rn.rem = r_s[k].rem - delta;
					rn.root = r_s[k].root | (RB'(1) << BIT);
				end
			end
		end else begin : g_sq_hold
			always_comb begin
				rn = r_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			c_s[k+1] <= c_s[k];
			d_s[k+1] <= dn;
			r_s[k+1] <= rn;
		end
	end

	// ---------------- resolution and output register ----------------
	ctl_t          cf;
	div_t          df;
	sqr_t          rf;
	logic [MW-1:0] qmag;
	logic [MW-1:0] smag;
	out_item_t     fin;
	out_item_t     result_q;
	logic          done_q;

	always_comb begin
		cf = c_s[QB];
		df = d_s[QB];
		rf = r_s[QB];
		qmag = MW'(df.quo) + MW'({df.rem, 1'b0} >= (DW+2)'(df.den));
		if (df.sat)
			qmag = {MW{1'b1}};
		smag = MW'(rf.root) + MW'(rf.rem > SW'(rf.root));

		fin.last_out = cf.last;
		fin.result_valid = cf.res_ok;
		unique case (cf.cls)
			CLS_DIV:  fin.result_value = sat_mag(cf.neg, qmag);
			CLS_SQRT: fin.result_value = cf.na ? '0 : sat_mag(1'b0, smag);
			CLS_MUL:  fin.result_value = cf.res;
			CLS_LOGIC: fin.result_value = cf.res;
		endcase
		if (cf.bad) begin
			fin.result_value = (op_t'(cf.op) == OP_ISNAN) ? ONE : '0;
			fin.result_valid = (op_t'(cf.op) == OP_ISNAN) || (op_t'(cf.op) == OP_NISNAN);
		end else if (cf.illegal) begin
			fin.result_value = '0;
			fin.result_valid = !cfg.illegal_gives_invalid;
		end else if (!cf.res_ok) begin
			fin.result_value = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= fin;
	end

	assign done = done_q;
	assign result = result_q;

endmodule

// ===== hdl/voxel_math_unit.sv =====
// voxel_math_unit: throughput is one item per cycle; the 33-step divide and
// square root pipeline in the back part sets the latency
// reset sets config registers to defaults (illegal results invalid) and empties
// the front, queue and pipeline; results are presented for one cycle, no stall
module voxel_math_unit import vmu_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  in_item_t       item,
	output out_item_t      result,
	output logic           done,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [CIW-1:0] cfg_index,
	input  data_t          cfg_data
);

	cfg_t     cfg_q;
	logic     q_full;
	logic     q_empty;
	logic     push;
	logic     pop;
	q_entry_t push_entry;
	q_entry_t head;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.op_select <= '0;
			cfg_q.second_from_input <= 1'b0;
			cfg_q.const_a <= '0;
			cfg_q.const_b <= '0;
			cfg_q.illegal_gives_invalid <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OP_SELECT:             cfg_q.op_select <= cfg_data[4:0];
				CFG_SECOND_FROM_INPUT:     cfg_q.second_from_input <= cfg_data[0];
				CFG_CONST_A:               cfg_q.const_a <= cfg_data;
				CFG_CONST_B:               cfg_q.const_b <= cfg_data;
				CFG_ILLEGAL_GIVES_INVALID: cfg_q.illegal_gives_invalid <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// accept and classify
	vmu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	// decoupling queue
	vmu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	// execute
	vmu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!q_empty),
		.entry    (head),
		.cfg      (cfg_q),
		.pop      (pop),
		.result   (result),
		.done     (done)
	);

endmodule
